/* rtl/time_ordered_retransmit_queue_defines.svh */
// Assertion macros for the time-ordered retransmit queue.
// No dependencies; included by the top level.
`ifndef TIME_ORDERED_RETRANSMIT_QUEUE_DEFINES_SVH
`define TIME_ORDERED_RETRANSMIT_QUEUE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define TORQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("queue check failed: same-cycle implication");

// Check that cons holds in the cycle after ante.
`define TORQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("queue check failed: next-cycle implication");

`endif

/* rtl/torq_pkg.sv */
// Shared types and codes for the time-ordered retransmit queue.
// No dependencies.
package torq_pkg;

  localparam int unsigned SeqW  = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned OccW  = 5;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_POP    = 2'd1,
    ACT_DELETE = 2'd2
  } torq_action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } torq_status_e;

  // One stored entry.
  typedef struct packed {
    logic [SeqW-1:0]  seq_num;
    logic [TimeW-1:0] sent_time;
  } torq_entry_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic             en;
    torq_action_e     op;
    logic [SeqW-1:0]  seq_num;
    logic [TimeW-1:0] sent_time;
  } torq_cmd_t;

endpackage

/* rtl/torq_in_if.sv */
// Input channel of the retransmit queue: valid/ready plus one command word.
// Depends on torq_pkg.
interface torq_in_if
  import torq_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [1:0]       action;
  logic [SeqW-1:0]  in_seq_num;
  logic [TimeW-1:0] in_sent_time;

  modport source (output valid, action, in_seq_num, in_sent_time, input ready);
  modport sink   (input valid, action, in_seq_num, in_sent_time, output ready);
endinterface

/* rtl/torq_out_if.sv */
// Output channel of the retransmit queue: valid/ready plus one result word.
// Depends on torq_pkg.
interface torq_out_if
  import torq_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [SeqW-1:0]  out_seq_num;
  logic [TimeW-1:0] out_sent_time;
  logic [1:0]       status;
  logic [OccW-1:0]  occupancy;

  modport source (output valid, out_seq_num, out_sent_time, status, occupancy,
                  input ready);
  modport sink   (input valid, out_seq_num, out_sent_time, status, occupancy,
                  output ready);
endinterface

/* rtl/torq_cell.sv */
// One slot of the sorted chain: holds an entry and trades with its neighbors.
// Depends on torq_pkg.
module torq_cell
  import torq_pkg::*;
(
  input  logic        clk_i,
  input  torq_cmd_t   cmd_i,
  input  logic        in_use_i,
  input  torq_entry_t left_i,
  input  logic        left_stay_i,
  input  torq_entry_t right_i,
  input  logic        found_i,
  output torq_entry_t entry_o,
  output logic        stay_o,
  output logic        found_o
);

  torq_entry_t ent_q, ent_d;
  logic        match;

  always_comb begin
    stay_o  = in_use_i && (ent_q.sent_time <= cmd_i.sent_time);
    match   = in_use_i && (ent_q.seq_num == cmd_i.seq_num);
    found_o = found_i | match;
    ent_d   = ent_q;
    unique case (cmd_i.op)
      ACT_INSERT: begin
        // keep earlier-or-equal entries, take the new word at the boundary,
        // shift the rest one slot toward the tail
        if (!stay_o) begin
          if (left_stay_i) begin
            ent_d.seq_num   = cmd_i.seq_num;
            ent_d.sent_time = cmd_i.sent_time;
          end else begin
            ent_d = left_i;
          end
        end
      end
      ACT_POP:    ent_d = right_i;
      ACT_DELETE: begin
        if (found_o) ent_d = right_i;
      end
      default:    ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.en) ent_q <= ent_d;
  end

  assign entry_o = ent_q;

endmodule

/* rtl/time_ordered_retransmit_queue.sv */
// Time-ordered retransmit queue: bounded sorted queue of (sequence, send time).
// Depends on torq_pkg, torq_in_if, torq_out_if, torq_cell and the defines header.
//
// Usage:
//   in_i  carries one command word: action (insert, pop earliest, delete by
//         sequence number), a sequence number and a send time.
//   out_o returns exactly one result word per command: popped entry (zero
//         unless a successful pop), status and the occupancy after the command.
// Entries sit in a row of QUEUE_DEPTH cells sorted by send time, head in
// cell 0. Each enabled command updates all cells in parallel: insert shifts later
// entries one cell toward the tail, pop and delete shift toward the head.
// The result is registered and shows in the cycle after acceptance.
// Throughput: one command per cycle while the receiver takes results; the
// cell update and the match chain across the row set the cycle.
// When out_o stalls, in_i holds ready low until the pending result is taken;
// no command is lost or reordered.
// Reset empties the queue at once (the count clears; cell contents are not
// cleared and are never read while unused). No clearing pass is needed.
`include "time_ordered_retransmit_queue_defines.svh"

module time_ordered_retransmit_queue
  import torq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  torq_in_if.sink    in_i,
  torq_out_if.source out_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q;
  torq_entry_t     out_ent_q, out_ent_d;
  torq_status_e    status_q, status_d;

  logic         accept;
  logic         full, empty;
  torq_action_e act;
  torq_cmd_t    cmd;

  torq_entry_t entry  [QUEUE_DEPTH];
  logic        stay   [QUEUE_DEPTH];
  logic        found  [QUEUE_DEPTH];

  // Accept a new word whenever the result register is free or draining.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign act        = torq_action_e'(in_i.action);
  assign full       = (cnt_q == CntW'(QUEUE_DEPTH));
  assign empty      = (cnt_q == '0);

  always_comb begin
    cmd.op        = act;
    cmd.seq_num   = in_i.in_seq_num;
    cmd.sent_time = in_i.in_sent_time;
    // Refused inserts and pops on empty leave the row alone.
    cmd.en        = accept && !((act == ACT_INSERT) && full)
                           && !((act == ACT_POP) && empty);
  end

  // Row of cells; cell 0 is the head, the last cell pulls in filler on shifts.
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    torq_entry_t left_ent, right_ent;
    logic        left_stay, found_in;

    if (g == 0) begin : g_head
      assign left_ent  = '0;
      assign left_stay = 1'b1;
      assign found_in  = 1'b0;
    end else begin : g_body
      assign left_ent  = entry[g-1];
      assign left_stay = stay[g-1];
      assign found_in  = found[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign right_ent = '0;
    end else begin : g_mid
      assign right_ent = entry[g+1];
    end

    torq_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .in_use_i    (CntW'(g) < cnt_q),
      .left_i      (left_ent),
      .left_stay_i (left_stay),
      .right_i     (right_ent),
      .found_i     (found_in),
      .entry_o     (entry[g]),
      .stay_o      (stay[g]),
      .found_o     (found[g])
    );
  end

  // Work out status, returned entry and the new count.
  always_comb begin
    cnt_d     = cnt_q;
    out_ent_d = '0;
    status_d  = ST_OK;
    unique case (act)
      ACT_INSERT: begin
        if (full) status_d = ST_FULL;
        else      cnt_d    = cnt_q + CntW'(1);
      end
      ACT_POP: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          out_ent_d = entry[0];
          cnt_d     = cnt_q - CntW'(1);
        end
      end
      ACT_DELETE: begin
        if (found[QUEUE_DEPTH-1]) cnt_d    = cnt_q - CntW'(1);
        else                      status_d = ST_NOT_FOUND;
      end
      default: ;
    endcase
  end

  // Hold the count and the result word; drop valid once the word is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_ent_q <= out_ent_d;
      status_q  <= status_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_seq_num   = out_ent_q.seq_num;
  assign out_o.out_sent_time = out_ent_q.sent_time;
  assign out_o.status        = status_q;
  assign out_o.occupancy     = OccW'(cnt_q);

  // Count stays within the row.
  `TORQ_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CntW'(QUEUE_DEPTH))
  // A pending result is never overwritten by a new word.
  `TORQ_ASSERT_IMP(a_no_overrun, clk_i, rst_ni, accept, !out_valid_q || out_o.ready)
  // A successful pop shrinks the queue by exactly one.
  `TORQ_ASSERT_NXT(a_pop_dec, clk_i, rst_ni, accept && (act == ACT_POP) && !empty, cnt_q == $past(cnt_q) - CntW'(1))
  // An insert into a full queue is reported as full and changes nothing.
  `TORQ_ASSERT_NXT(a_full_refuse, clk_i, rst_ni, accept && (act == ACT_INSERT) && full, (status_q == ST_FULL) && $stable(cnt_q))

endmodule
